### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bavd_pkg.sv
package bavd_pkg;

    // Samples per block; a block is closed by the item that follows the last one.
    localparam int BLOCK_LENGTH = 8;

    localparam int NUM_CH   = 4;
    localparam int SAMPLE_W = 10;
    localparam int TRUNC_W  = 8;
    localparam int CHAR_W   = 6;
    localparam int DIGIT_W  = 4;
    localparam int COUNT_W  = $clog2(BLOCK_LENGTH + 1);
    localparam int SUM_W    = TRUNC_W + $clog2(BLOCK_LENGTH);

    // Exact floor division by BLOCK_LENGTH for any sum below 2**SUM_W:
    // avg = (sum * DIV_MULT) >> DIV_SHIFT.
    localparam int DIV_SHIFT = SUM_W + $clog2(BLOCK_LENGTH);
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'((2 ** DIV_SHIFT + BLOCK_LENGTH - 1) / BLOCK_LENGTH);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [TRUNC_W-1:0]  t_avg;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [DIGIT_W-1:0]  t_digit;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_sum_vec;

    typedef struct packed {
        t_digit hundreds;
        t_digit tens;
        t_digit units;
    } t_bcd;

    typedef struct packed {
        t_char hundreds;
        t_char tens;
        t_char units;
    } t_chars;

    // Block sums offered to the divide stage together with their valid.
    typedef struct packed {
        logic     vld;
        t_sum_vec sums;
    } t_sum_beat;

    // Shift-and-add-three conversion of an 8-bit value to three BCD digits.
    function automatic t_bcd bin_to_bcd(input t_avg value);
        logic [3*DIGIT_W+TRUNC_W-1:0] shreg;
        t_bcd                         res;
        shreg = {{(3*DIGIT_W){1'b0}}, value};
        for (int i = 0; i < TRUNC_W; i++) begin
            for (int d = 0; d < 3; d++) begin
                if (shreg[TRUNC_W + DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
                    shreg[TRUNC_W + DIGIT_W*d +: DIGIT_W] =
                        shreg[TRUNC_W + DIGIT_W*d +: DIGIT_W] + 4'd3;
                end
            end
            shreg = shreg << 1;
        end
        res.hundreds = shreg[TRUNC_W + 2*DIGIT_W +: DIGIT_W];
        res.tens     = shreg[TRUNC_W + DIGIT_W +: DIGIT_W];
        res.units    = shreg[TRUNC_W +: DIGIT_W];
        return res;
    endfunction

    function automatic t_char digit_char(input t_digit dig);
        return ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig};
    endfunction

endpackage

### design/bavd_if.sv
interface bavd_in_if;
    import bavd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_ch0;
    t_sample sample_ch1;
    t_sample sample_ch2;
    t_sample sample_ch3;

    modport source (
        output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
        input  ready
    );
    modport sink (
        input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
        output ready
    );
endinterface

interface bavd_out_if;
    import bavd_pkg::*;

    logic  valid;
    logic  ready;
    t_char ch0_hundreds_char;
    t_char ch0_tens_char;
    t_char ch0_units_char;
    t_char ch1_hundreds_char;
    t_char ch1_tens_char;
    t_char ch1_units_char;
    t_char ch2_hundreds_char;
    t_char ch2_tens_char;
    t_char ch2_units_char;
    t_char ch3_hundreds_char;
    t_char ch3_tens_char;
    t_char ch3_units_char;

    modport source (
        output valid,
        output ch0_hundreds_char, ch0_tens_char, ch0_units_char,
        output ch1_hundreds_char, ch1_tens_char, ch1_units_char,
        output ch2_hundreds_char, ch2_tens_char, ch2_units_char,
        output ch3_hundreds_char, ch3_tens_char, ch3_units_char,
        input  ready
    );
    modport sink (
        input  valid,
        input  ch0_hundreds_char, ch0_tens_char, ch0_units_char,
        input  ch1_hundreds_char, ch1_tens_char, ch1_units_char,
        input  ch2_hundreds_char, ch2_tens_char, ch2_units_char,
        input  ch3_hundreds_char, ch3_tens_char, ch3_units_char,
        output ready
    );
endinterface

### design/bavd_avg_conv.sv
`include "assert_macros.svh"

module bavd_avg_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bavd_pkg::t_sum_beat i_beat,
    output logic                o_beat_rdy,
    bavd_out_if.source          o_out
);
    import bavd_pkg::*;

    logic                r_avg_vld;
    logic                n_avg_vld;
    t_avg [NUM_CH-1:0]   r_avg;
    t_avg [NUM_CH-1:0]   n_avg;
    logic                r_out_vld;
    logic                n_out_vld;
    t_chars [NUM_CH-1:0] r_chars;
    t_chars [NUM_CH-1:0] n_chars;

    logic                      out_free;
    logic                      avg_take;
    logic [NUM_CH-1:0][PROD_W-1:0] w_prod;
    t_bcd [NUM_CH-1:0]         w_bcd;
    logic                      w_hund_ok;

    assign out_free   = !r_out_vld || o_out.ready;
    assign avg_take   = r_avg_vld && out_free;
    assign o_beat_rdy = !r_avg_vld || out_free;

    // Divide stage: one reciprocal multiply per channel, then the result register.
    always_comb begin
        n_avg_vld = r_avg_vld;
        n_avg     = r_avg;
        for (int c = 0; c < NUM_CH; c++) begin
            w_prod[c] = PROD_W'(i_beat.sums[c]) * PROD_W'(DIV_MULT);
        end
        if (o_beat_rdy) begin
            n_avg_vld = i_beat.vld;
            if (i_beat.vld) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    n_avg[c] = w_prod[c][DIV_SHIFT +: TRUNC_W];
                end
            end
        end
    end

    // Conversion stage: BCD digits, then ASCII characters into the output register.
    always_comb begin
        n_out_vld = r_out_vld;
        n_chars   = r_chars;
        for (int c = 0; c < NUM_CH; c++) begin
            w_bcd[c] = bin_to_bcd(r_avg[c]);
        end
        if (out_free) begin
            n_out_vld = r_avg_vld;
            if (avg_take) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    n_chars[c].hundreds = digit_char(w_bcd[c].hundreds);
                    n_chars[c].tens     = digit_char(w_bcd[c].tens);
                    n_chars[c].units    = digit_char(w_bcd[c].units);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_avg_vld <= n_avg_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_avg   <= n_avg;
        r_chars <= n_chars;
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.ch0_hundreds_char = r_chars[0].hundreds;
    assign o_out.ch0_tens_char     = r_chars[0].tens;
    assign o_out.ch0_units_char    = r_chars[0].units;
    assign o_out.ch1_hundreds_char = r_chars[1].hundreds;
    assign o_out.ch1_tens_char     = r_chars[1].tens;
    assign o_out.ch1_units_char    = r_chars[1].units;
    assign o_out.ch2_hundreds_char = r_chars[2].hundreds;
    assign o_out.ch2_tens_char     = r_chars[2].tens;
    assign o_out.ch2_units_char    = r_chars[2].units;
    assign o_out.ch3_hundreds_char = r_chars[3].hundreds;
    assign o_out.ch3_tens_char     = r_chars[3].tens;
    assign o_out.ch3_units_char    = r_chars[3].units;

    // An average never exceeds 255, so every hundreds character is '0' to '2'.
    always_comb begin
        w_hund_ok = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_chars[c].hundreds > ASCII_ZERO + 6'd2) begin
                w_hund_ok = 1'b0;
            end
        end
    end

    `ASSERT_NOW(a_hund_range, i_clk, i_rst_n, r_out_vld, w_hund_ok, "hundreds digit above two")
    `ASSERT_NEXT(a_avg_hold, i_clk, i_rst_n, r_avg_vld && !out_free, r_avg_vld && $stable(r_avg), "stalled average lost or changed")

endmodule

### design/four_channel_block_average_to_decimal.sv
// Channel   Dir  Modport        Carries
// i_in      in   bavd_in_if     four 10-bit converter samples per transfer
// o_out     out  bavd_out_if    twelve ASCII digits, three per channel average
//
// One input transfer may be taken every cycle. Accumulating transfers are always
// accepted; a closing transfer (counter at the block length) waits only if the divide
// stage is full. Its result passes through the divide register and then the output
// register. Synchronous active-low reset clears the sums, the counter and both stage
// valids. Back-pressure on o_out stalls the two result registers and, through them, a closing transfer.
`include "assert_macros.svh"

module four_channel_block_average_to_decimal (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bavd_in_if.sink    i_in,
    bavd_out_if.source o_out
);
    import bavd_pkg::*;

    // Running per-channel sums of the truncated samples and the item counter.
    t_sum_vec  r_sums;
    t_sum_vec  n_sums;
    t_count    r_count;
    t_count    n_count;

    logic      closing;
    logic      in_fire;
    logic      w_beat_rdy;
    t_sum_beat w_beat;
    t_sample   w_sample [NUM_CH];

    assign w_sample[0] = i_in.sample_ch0;
    assign w_sample[1] = i_in.sample_ch1;
    assign w_sample[2] = i_in.sample_ch2;
    assign w_sample[3] = i_in.sample_ch3;

    // The item that finds the counter at the block length closes the block: its
    // samples are dropped and the sums move on to the divide stage.
    assign closing    = (r_count == COUNT_W'(BLOCK_LENGTH));
    assign i_in.ready = !closing || w_beat_rdy;
    assign in_fire    = i_in.valid && i_in.ready;

    // The divide stage loads the sums straight from the accumulator registers.
    assign w_beat.vld  = i_in.valid && closing;
    assign w_beat.sums = r_sums;

    always_comb begin
        n_sums  = r_sums;
        n_count = r_count;
        if (in_fire) begin
            if (closing) begin
                n_sums  = '0;
                n_count = '0;
            end else begin
                for (int c = 0; c < NUM_CH; c++) begin
                    n_sums[c] = r_sums[c] + SUM_W'(w_sample[c][SAMPLE_W-1 -: TRUNC_W]);
                end
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums  <= '0;
            r_count <= '0;
        end else begin
            r_sums  <= n_sums;
            r_count <= n_count;
        end
    end

    bavd_avg_conv u_avg_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (w_beat),
        .o_beat_rdy (w_beat_rdy),
        .o_out      (o_out)
    );

    `ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= COUNT_W'(BLOCK_LENGTH), "block counter past block length")
    `ASSERT_NEXT(a_close_clear, i_clk, i_rst_n, in_fire && closing, r_count == '0 && r_sums == '0, "block not cleared after closing transfer")
    `ASSERT_NEXT(a_count_step, i_clk, i_rst_n, in_fire && !closing, r_count == $past(r_count) + COUNT_W'(1), "counter did not advance")

endmodule
